[design/jx1_pkg.sv]
// shared types, constants and the control program of the jacobi(0,2) times (x+1) unit
// no dependencies
`default_nettype none

package jx1_pkg;

  localparam int COEF_W    = 32;
  localparam int IDX_OUT_W = 10;
  localparam int QUO_W     = 32;
  localparam int CNT_W     = $clog2(QUO_W);
  // three rounded taps plus the middle sample, with room to spare before saturation
  localparam int ACC_W     = COEF_W + 3;
  localparam int PC_W      = 5;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_WAIT,
    OP_LOAD_ROW1,
    OP_LOAD_ROW2,
    OP_SETUP_A,
    OP_SETUP_B,
    OP_SETUP_C,
    OP_MUL,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_ACC,
    OP_ACC_MID,
    OP_EMIT,
    OP_ADVANCE,
    OP_RESTART
  } op_e;

  typedef enum logic [2:0] {
    CND_NONE,
    CND_ALWAYS,
    CND_NO_INPUT,
    CND_FIRST,
    CND_DIV_MORE,
    CND_OUT_BUSY,
    CND_ROW_LAST,
    CND_FIN
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [PC_W-1:0]  target;
  } uword_t;

  typedef struct packed {
    logic no_input;
    logic first;
    logic div_more;
    logic out_busy;
    logic row_last;
    logic fin;
  } status_t;

  typedef struct packed {
    logic first;
    logic row_last;
    logic fin;
  } dp_flags_t;

  // program labels
  localparam logic [PC_W-1:0] STEP_WAIT    = PC_W'(0);
  localparam logic [PC_W-1:0] STEP_ROW2    = PC_W'(3);
  localparam logic [PC_W-1:0] STEP_TAP_A   = PC_W'(4);
  localparam logic [PC_W-1:0] STEP_DIV_A   = PC_W'(7);
  localparam logic [PC_W-1:0] STEP_DIV_B   = PC_W'(12);
  localparam logic [PC_W-1:0] STEP_DIV_C   = PC_W'(17);
  localparam logic [PC_W-1:0] STEP_EMIT    = PC_W'(19);
  localparam logic [PC_W-1:0] STEP_CHK_FIN = PC_W'(21);
  localparam logic [PC_W-1:0] STEP_RESTART = PC_W'(23);

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      5'd0:  w = '{OP_WAIT,      CND_NO_INPUT, STEP_WAIT};
      5'd1:  w = '{OP_NOP,       CND_FIRST,    STEP_CHK_FIN};
      5'd2:  w = '{OP_LOAD_ROW1, CND_ALWAYS,   STEP_TAP_A};
      5'd3:  w = '{OP_LOAD_ROW2, CND_NONE,     STEP_WAIT};
      5'd4:  w = '{OP_SETUP_A,   CND_NONE,     STEP_WAIT};
      5'd5:  w = '{OP_MUL,       CND_NONE,     STEP_WAIT};
      5'd6:  w = '{OP_DIV_LOAD,  CND_NONE,     STEP_WAIT};
      5'd7:  w = '{OP_DIV_STEP,  CND_DIV_MORE, STEP_DIV_A};
      5'd8:  w = '{OP_ACC,       CND_NONE,     STEP_WAIT};
      5'd9:  w = '{OP_SETUP_B,   CND_NONE,     STEP_WAIT};
      5'd10: w = '{OP_MUL,       CND_NONE,     STEP_WAIT};
      5'd11: w = '{OP_DIV_LOAD,  CND_NONE,     STEP_WAIT};
      5'd12: w = '{OP_DIV_STEP,  CND_DIV_MORE, STEP_DIV_B};
      5'd13: w = '{OP_ACC_MID,   CND_NONE,     STEP_WAIT};
      5'd14: w = '{OP_SETUP_C,   CND_NONE,     STEP_WAIT};
      5'd15: w = '{OP_MUL,       CND_NONE,     STEP_WAIT};
      5'd16: w = '{OP_DIV_LOAD,  CND_NONE,     STEP_WAIT};
      5'd17: w = '{OP_DIV_STEP,  CND_DIV_MORE, STEP_DIV_C};
      5'd18: w = '{OP_ACC,       CND_NONE,     STEP_WAIT};
      5'd19: w = '{OP_EMIT,      CND_OUT_BUSY, STEP_EMIT};
      5'd20: w = '{OP_NOP,       CND_ROW_LAST, STEP_RESTART};
      5'd21: w = '{OP_NOP,       CND_FIN,      STEP_ROW2};
      5'd22: w = '{OP_ADVANCE,   CND_ALWAYS,   STEP_WAIT};
      5'd23: w = '{OP_RESTART,   CND_ALWAYS,   STEP_WAIT};
      default: w = '{OP_NOP,     CND_ALWAYS,   STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[design/jx1_useq.sv]
// step counter and program table of the unit, picks the next step from the status flags
// depends on jx1_pkg
`default_nettype none

module jx1_useq
  import jx1_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire status_t status_i,
  output uword_t       ctrl_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          word;
  logic            jump;

  assign word   = ucode(pc_q);
  assign ctrl_o = word;

  always_comb begin
    case (word.cond)
      CND_NONE:     jump = 1'b0;
      CND_ALWAYS:   jump = 1'b1;
      CND_NO_INPUT: jump = status_i.no_input;
      CND_FIRST:    jump = status_i.first;
      CND_DIV_MORE: jump = status_i.div_more;
      CND_OUT_BUSY: jump = status_i.out_busy;
      CND_ROW_LAST: jump = status_i.row_last;
      CND_FIN:      jump = status_i.fin;
      default:      jump = 1'b0;
    endcase
    pc_d = jump ? word.target : pc_q + PC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

[design/jx1_div.sv]
// restoring divider, one quotient bit per step, quotient of fixed width
// depends on jx1_pkg
`default_nettype none

module jx1_div
  import jx1_pkg::*;
#(
  parameter int NUM_W = 23,
  parameter int DIV_W = QUO_W + NUM_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire logic             step_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [NUM_W-1:0] divisor_i,
  output logic                  more_o,
  output logic [QUO_W-1:0]      quo_o
);

  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] rem_q, den_q;
  logic [QUO_W-1:0] quo_q;
  logic [NUM_W:0]   trial, diff;
  logic             fits;

  assign trial  = {rem_q, quo_q[QUO_W-1]};
  assign diff   = trial - {1'b0, den_q};
  assign fits   = trial >= {1'b0, den_q};
  assign more_o = cnt_q != CNT_W'(QUO_W - 1);
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  // high part of the dividend is below the divisor, so the quotient fits
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= dividend_i[DIV_W-1:QUO_W];
      quo_q <= dividend_i[QUO_W-1:0];
      den_q <= divisor_i;
    end else if (step_i) begin
      rem_q <= fits ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

[design/jx1_dpath.sv]
// datapath: sample history, tap weights, shared multiplier, accumulator and saturation
// depends on jx1_pkg; quotients come from jx1_div
`default_nettype none

module jx1_dpath
  import jx1_pkg::*;
#(
  parameter int MAX_LEN = 1024,
  parameter int IDX_W   = $clog2(MAX_LEN),
  parameter int NUM_W   = 2 * IDX_W + 3,
  parameter int DIV_W   = QUO_W + NUM_W
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire uword_t                   ctrl_i,
  input  wire logic                     in_valid_i,
  input  wire logic signed [COEF_W-1:0] coef_in_i,
  input  wire logic                     is_final_i,
  input  wire logic [QUO_W-1:0]         quo_i,
  output logic [DIV_W-1:0]              prod_o,
  output logic [NUM_W-1:0]              den_o,
  output dp_flags_t                     flags_o,
  output logic signed [COEF_W-1:0]      sum_o,
  output logic [IDX_OUT_W-1:0]          idx_o,
  output logic                          last_o
);

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(MAX_LEN - 1);
  localparam logic signed [ACC_W-1:0] SatHi =
    {{(ACC_W-COEF_W+1){1'b0}}, {(COEF_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SatLo =
    {{(ACC_W-COEF_W+1){1'b1}}, {(COEF_W-1){1'b0}}};

  // series state
  logic signed [COEF_W-1:0] p_q, pp_q;
  logic [IDX_W-1:0]         count_q;
  // current item
  logic signed [COEF_W-1:0] x_q;
  logic                     fin_q;
  // current row window
  logic signed [COEF_W-1:0] l_q, m_q, r_q;
  logic [IDX_W-1:0]         idx_q;
  logic                     last_q;
  // tap operands
  logic [NUM_W-1:0]         num_q, den_q;
  logic [COEF_W-1:0]        mag_q;
  logic                     neg_q;
  logic [DIV_W-1:0]         prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  logic [NUM_W-1:0]         e, fa, fb, fc, fd;
  logic signed [COEF_W-1:0] samp;
  logic signed [ACC_W-1:0]  q_ext, tap, mid_ext;
  logic                     setup;

  assign e = NUM_W'(idx_q);

  always_comb begin
    setup = 1'b1;
    samp  = l_q;
    fa    = '0;
    fb    = '0;
    fc    = '0;
    fd    = '0;
    case (ctrl_i.op)
      OP_SETUP_A: begin
        samp = l_q;
        fa   = e;
        fb   = e + NUM_W'(2);
        fc   = e + NUM_W'(1);
        fd   = (e << 1) + NUM_W'(1);
      end
      OP_SETUP_B: begin
        samp = m_q;
        fa   = NUM_W'(1);
        fb   = NUM_W'(1);
        fc   = e + NUM_W'(1);
        fd   = e + NUM_W'(2);
      end
      OP_SETUP_C: begin
        samp = r_q;
        fa   = e + NUM_W'(1);
        fb   = e + NUM_W'(3);
        fc   = e + NUM_W'(2);
        fd   = (e << 1) + NUM_W'(5);
      end
      default: setup = 1'b0;
    endcase
  end

  assign q_ext   = ACC_W'({1'b0, quo_i});
  assign tap     = neg_q ? -q_ext : q_ext;
  assign mid_ext = ACC_W'(m_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q     <= '0;
      pp_q    <= '0;
      count_q <= '0;
    end else if (ctrl_i.op == OP_ADVANCE) begin
      pp_q    <= p_q;
      p_q     <= x_q;
      count_q <= count_q + IDX_W'(1);
    end else if (ctrl_i.op == OP_RESTART) begin
      pp_q    <= '0;
      p_q     <= '0;
      count_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == OP_WAIT && in_valid_i) begin
      x_q   <= coef_in_i;
      // an overlong series ends at the last index that fits
      fin_q <= is_final_i || (count_q >= LastIdx);
    end
    if (ctrl_i.op == OP_LOAD_ROW1) begin
      l_q    <= pp_q;
      m_q    <= p_q;
      r_q    <= x_q;
      idx_q  <= count_q - IDX_W'(1);
      last_q <= 1'b0;
    end
    if (ctrl_i.op == OP_LOAD_ROW2) begin
      l_q    <= p_q;
      m_q    <= x_q;
      r_q    <= '0;
      idx_q  <= count_q;
      last_q <= 1'b1;
    end
    if (setup) begin
      num_q <= fa * fb;
      den_q <= fc * fd;
      neg_q <= samp[COEF_W-1];
      mag_q <= samp[COEF_W-1] ? COEF_W'(-samp) : COEF_W'(samp);
    end
    if (ctrl_i.op == OP_SETUP_A) begin
      acc_q <= '0;
    end
    if (ctrl_i.op == OP_MUL) begin
      // magnitude times numerator plus half the denominator, for round half away
      prod_q <= DIV_W'(mag_q) * DIV_W'(num_q) + DIV_W'(den_q >> 1);
    end
    if (ctrl_i.op == OP_ACC) begin
      acc_q <= acc_q + tap;
    end
    if (ctrl_i.op == OP_ACC_MID) begin
      acc_q <= acc_q + tap + mid_ext;
    end
  end

  always_comb begin
    if (acc_q > SatHi) begin
      sum_o = SatHi[COEF_W-1:0];
    end else if (acc_q < SatLo) begin
      sum_o = SatLo[COEF_W-1:0];
    end else begin
      sum_o = acc_q[COEF_W-1:0];
    end
  end

  assign prod_o           = prod_q;
  assign den_o            = den_q;
  assign idx_o            = IDX_OUT_W'(idx_q);
  assign last_o           = last_q;
  assign flags_o.first    = count_q == '0;
  assign flags_o.row_last = last_q;
  assign flags_o.fin      = fin_q;

endmodule

`default_nettype wire

[design/jacobi02_times_x_plus_one_unit.sv]
// top level: jacobi(0,2) series times (x+1), streamed coefficient by coefficient
// depends on jx1_pkg, jx1_useq, jx1_dpath, jx1_div
//
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+--------------------------
//  in      | coef_in_i, is_final_i                     | in_valid_i && in_ready_o
//  out     | coef_out_o, coef_index_o, run_end_o       | out_valid_o && out_ready_i
//
// one coefficient is taken at a time; the 32-step divider, shared by the three taps
// of a row, sets the pace: the first coefficient of a series completes no row unless it
// is final, one that completes a row runs three divisions, and the final one completes two rows.
// reset clears the history and starts a new series at index 0.
// a result waits in the output register; the program stalls only when a second one is
// ready before the first has been taken.
`default_nettype none

module jacobi02_times_x_plus_one_unit
  import jx1_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [COEF_W-1:0] coef_in_i,
  input  wire logic                     is_final_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [COEF_W-1:0]      coef_out_o,
  output logic [IDX_OUT_W-1:0]          coef_index_o,
  output logic                          run_end_o
);

  localparam int IdxW = $clog2(MAX_LEN);
  localparam int NumW = 2 * IdxW + 3;
  localparam int DivW = QUO_W + NumW;

  uword_t           ctrl;
  status_t          status;
  dp_flags_t        flags;
  logic [DivW-1:0]  prod;
  logic [NumW-1:0]  den;
  logic [QUO_W-1:0] quo;
  logic             div_more;
  logic signed [COEF_W-1:0] sum;
  logic [IDX_OUT_W-1:0]     idx;
  logic             last;

  logic                     out_valid_q;
  logic signed [COEF_W-1:0] coef_out_q;
  logic [IDX_OUT_W-1:0]     coef_index_q;
  logic                     run_end_q;
  logic                     out_busy, emit;

  assign in_ready_o = ctrl.op == OP_WAIT;
  assign out_busy   = out_valid_q && !out_ready_i;
  assign emit       = (ctrl.op == OP_EMIT) && !out_busy;

  assign status.no_input = !in_valid_i;
  assign status.first    = flags.first;
  assign status.div_more = div_more;
  assign status.out_busy = out_busy;
  assign status.row_last = flags.row_last;
  assign status.fin      = flags.fin;

  jx1_useq u_useq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  jx1_dpath #(
    .MAX_LEN (MAX_LEN),
    .IDX_W   (IdxW),
    .NUM_W   (NumW),
    .DIV_W   (DivW)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .in_valid_i (in_valid_i),
    .coef_in_i  (coef_in_i),
    .is_final_i (is_final_i),
    .quo_i      (quo),
    .prod_o     (prod),
    .den_o      (den),
    .flags_o    (flags),
    .sum_o      (sum),
    .idx_o      (idx),
    .last_o     (last)
  );

  jx1_div #(
    .NUM_W (NumW),
    .DIV_W (DivW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (ctrl.op == OP_DIV_LOAD),
    .step_i     (ctrl.op == OP_DIV_STEP),
    .dividend_i (prod),
    .divisor_i  (den),
    .more_o     (div_more),
    .quo_o      (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      coef_out_q   <= sum;
      coef_index_q <= idx;
      run_end_q    <= last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign coef_out_o   = coef_out_q;
  assign coef_index_o = coef_index_q;
  assign run_end_o    = run_end_q;

endmodule

`default_nettype wire
